@@ rtl/dfs_maze_carver_assert.svh @@
// Assertion macros shared by the maze carver.
`ifndef DFS_MAZE_CARVER_ASSERT_SVH
`define DFS_MAZE_CARVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dmc_pkg;
    localparam int MAX_SIDE    = 63;
    localparam int STACK_DEPTH = 1024;
    localparam int MIN_SIDE    = 3;
    localparam int SIZE_RESET  = 11;
    localparam int COORD_W     = 6;
    localparam int ROW_W       = 63;
    localparam int ROW_AW      = $clog2(MAX_SIDE);
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W       = STACK_AW + 1;
    localparam int ORDER_W     = 8;
    localparam int TRIES_W     = 3;
    localparam int ENTRY_W     = TRIES_W + ORDER_W + 2 * COORD_W;
    localparam int OUT_W       = 72;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    typedef struct packed {
        logic start;
        logic set_order;
        logic try_adv;
        logic rd_target;
        logic wr_target;
        logic rd_mid;
        logic wr_mid;
        logic push;
        logic pop_rd;
        logic pop_ld;
        logic pop_last;
        logic out_rd;
        logic out_ld;
        logic out_next;
    } cmd_t;

    typedef struct packed {
        logic k_done;
        logic move_ok;
        logic target_open;
        logic stack_full;
        logic count_one;
        logic vertical;
        logic last_row;
    } status_t;
endpackage
`default_nettype wire

@@ rtl/dmc_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dmc_dpath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [dmc_pkg::COORD_W-1:0]  maze_size,
    input  wire logic [dmc_pkg::ORDER_W-1:0]  order,
    input  wire dmc_pkg::cmd_t                cmd,
    output dmc_pkg::status_t                  status,
    output logic [dmc_pkg::OUT_W-1:0]         out_data,
    output logic                              out_last
);
    import dmc_pkg::*;

    logic [ROW_W-1:0]   grid_mem [MAX_SIDE];
    logic [ENTRY_W-1:0] stack_mem [STACK_DEPTH];

    logic [COORD_W-1:0] side;
    logic [COORD_W-1:0] top_r_reg, top_c_reg;
    logic [ORDER_W-1:0] top_ord_reg;
    logic [TRIES_W-1:0] top_k_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [COORD_W-1:0] tr_reg, tc_reg, mr_reg, mc_reg;
    logic               vert_reg;
    logic [ROW_W-1:0]   grid_q_reg;
    logic [ROW_AW-1:0]  rd_addr_reg;
    logic [MAX_SIDE-1:0] row_valid_reg;
    logic [ENTRY_W-1:0] stack_q_reg;
    logic [ROW_W-1:0]   out_bits_reg;
    logic [COORD_W-1:0] out_idx_reg;
    logic               out_last_reg;

    dir_t               cur_dir;
    logic               ok_next;
    logic [COORD_W:0]   r7, c7, side7;
    logic [COORD_W-1:0] tr_next, tc_next, mr_next, mc_next;
    logic [ROW_AW-1:0]  rd_addr;
    logic               rd_en;
    logic [ROW_W-1:0]   base, tc_bit, mc_bit, side_mask;
    logic [STACK_AW-1:0] push_addr, pop_addr;

    always_comb begin
        side = maze_size;
        if (maze_size < COORD_W'(MIN_SIDE)) begin
            side = COORD_W'(MIN_SIDE);
        end else if (maze_size > COORD_W'(MAX_SIDE)) begin
            side = COORD_W'(MAX_SIDE);
        end
    end

    assign r7      = {1'b0, top_r_reg};
    assign c7      = {1'b0, top_c_reg};
    assign side7   = {1'b0, side};
    assign cur_dir = dir_t'(top_ord_reg[{top_k_reg[1:0], 1'b0} +: 2]);

    always_comb begin
        tr_next = top_r_reg;
        tc_next = top_c_reg;
        mr_next = top_r_reg;
        mc_next = top_c_reg;
        unique case (cur_dir)
            DIR_UP: begin
                ok_next = top_r_reg > COORD_W'(2);
                tr_next = top_r_reg - COORD_W'(2);
                mr_next = top_r_reg - COORD_W'(1);
            end
            DIR_RIGHT: begin
                ok_next = (c7 + (COORD_W + 1)'(3)) < side7;
                tc_next = top_c_reg + COORD_W'(2);
                mc_next = top_c_reg + COORD_W'(1);
            end
            DIR_DOWN: begin
                ok_next = (r7 + (COORD_W + 1)'(3)) < side7;
                tr_next = top_r_reg + COORD_W'(2);
                mr_next = top_r_reg + COORD_W'(1);
            end
            DIR_LEFT: begin
                ok_next = top_c_reg > COORD_W'(2);
                tc_next = top_c_reg - COORD_W'(2);
                mc_next = top_c_reg - COORD_W'(1);
            end
        endcase
    end

    always_comb begin
        rd_en   = cmd.rd_target | cmd.rd_mid | cmd.out_rd;
        rd_addr = out_idx_reg;
        priority if (cmd.rd_target) begin
            rd_addr = tr_next;
        end else if (cmd.rd_mid) begin
            rd_addr = mr_reg;
        end
    end

    assign base      = row_valid_reg[rd_addr_reg] ? grid_q_reg : '0;
    assign tc_bit    = ROW_W'(1) << tc_reg;
    assign mc_bit    = ROW_W'(1) << mc_reg;
    assign side_mask = ~({ROW_W{1'b1}} << side);
    assign push_addr = STACK_AW'(count_reg - CNT_W'(1));
    assign pop_addr  = STACK_AW'(count_reg - CNT_W'(2));

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            grid_q_reg  <= grid_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (cmd.start) begin
            grid_mem[1] <= ROW_W'(2);
        end else if (cmd.wr_target) begin
            grid_mem[tr_reg] <= base | tc_bit | (vert_reg ? '0 : mc_bit);
        end else if (cmd.wr_mid) begin
            grid_mem[mr_reg] <= base | mc_bit;
        end
        if (cmd.push) begin
            stack_mem[push_addr] <= {top_k_reg, top_ord_reg, top_c_reg, top_r_reg};
        end
        if (cmd.pop_rd) begin
            stack_q_reg <= stack_mem[pop_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            row_valid_reg <= '0;
        end else begin
            if (cmd.start) begin
                row_valid_reg <= MAX_SIDE'(2);
                count_reg     <= CNT_W'(1);
            end else begin
                if (cmd.wr_target) begin
                    row_valid_reg[tr_reg] <= 1'b1;
                end
                if (cmd.wr_mid) begin
                    row_valid_reg[mr_reg] <= 1'b1;
                end
                priority if (cmd.push) begin
                    count_reg <= count_reg + CNT_W'(1);
                end else if (cmd.pop_rd) begin
                    count_reg <= count_reg - CNT_W'(1);
                end else if (cmd.pop_last) begin
                    count_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            top_r_reg   <= COORD_W'(1);
            top_c_reg   <= COORD_W'(1);
            top_ord_reg <= order;
            top_k_reg   <= '0;
        end else if (cmd.set_order) begin
            top_ord_reg <= order;
            top_k_reg   <= '0;
        end else if (cmd.try_adv) begin
            top_k_reg <= top_k_reg + TRIES_W'(1);
            tr_reg    <= tr_next;
            tc_reg    <= tc_next;
            mr_reg    <= mr_next;
            mc_reg    <= mc_next;
            vert_reg  <= (cur_dir == DIR_UP) || (cur_dir == DIR_DOWN);
        end else if (cmd.push) begin
            top_r_reg   <= tr_reg;
            top_c_reg   <= tc_reg;
            top_ord_reg <= '0;
            top_k_reg   <= '0;
        end else if (cmd.pop_ld) begin
            {top_k_reg, top_ord_reg, top_c_reg, top_r_reg} <= stack_q_reg;
        end
        if (cmd.pop_last) begin
            out_idx_reg <= '0;
        end else if (cmd.out_next) begin
            out_idx_reg <= out_idx_reg + COORD_W'(1);
        end
        if (cmd.out_ld) begin
            out_bits_reg <= base & side_mask;
            out_last_reg <= out_idx_reg == (side - COORD_W'(1));
        end
    end

    always_comb begin
        status.k_done      = top_k_reg[TRIES_W-1];
        status.move_ok     = ok_next;
        status.target_open = base[tc_reg];
        status.stack_full  = count_reg == CNT_W'(STACK_DEPTH);
        status.count_one   = count_reg == CNT_W'(1);
        status.vertical    = vert_reg;
        status.last_row    = out_last_reg;
    end

    assign out_data = {{(OUT_W - ROW_W - COORD_W){1'b0}}, out_bits_reg, out_idx_reg};
    assign out_last = out_last_reg;
endmodule
`default_nettype wire

@@ rtl/dmc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dmc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire dmc_pkg::status_t  status,
    output dmc_pkg::cmd_t          cmd
);
    import dmc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WAIT, ST_TRY, ST_CHECK, ST_RMID, ST_WMID,
        ST_POPLD, ST_ERD, ST_ELD, ST_EOUT
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE) || (state_reg == ST_WAIT);
    assign m_tvalid = state_reg == ST_EOUT;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_TRY;
                end
            end
            ST_WAIT: begin
                if (s_tvalid) begin
                    cmd.set_order = 1'b1;
                    state_next    = ST_TRY;
                end
            end
            ST_TRY: begin
                if (status.k_done) begin
                    if (status.count_one) begin
                        cmd.pop_last = 1'b1;
                        state_next   = ST_ERD;
                    end else begin
                        cmd.pop_rd = 1'b1;
                        state_next = ST_POPLD;
                    end
                end else begin
                    cmd.try_adv = 1'b1;
                    if (status.move_ok) begin
                        cmd.rd_target = 1'b1;
                        state_next    = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (status.target_open || status.stack_full) begin
                    state_next = ST_TRY;
                end else begin
                    cmd.wr_target = 1'b1;
                    if (status.vertical) begin
                        state_next = ST_RMID;
                    end else begin
                        cmd.push   = 1'b1;
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_RMID: begin
                cmd.rd_mid = 1'b1;
                state_next = ST_WMID;
            end
            ST_WMID: begin
                cmd.wr_mid = 1'b1;
                cmd.push   = 1'b1;
                state_next = ST_WAIT;
            end
            ST_POPLD: begin
                cmd.pop_ld = 1'b1;
                state_next = ST_TRY;
            end
            ST_ERD: begin
                cmd.out_rd = 1'b1;
                state_next = ST_ELD;
            end
            ST_ELD: begin
                cmd.out_ld = 1'b1;
                state_next = ST_EOUT;
            end
            ST_EOUT: begin
                if (m_tready) begin
                    if (status.last_row) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.out_next = 1'b1;
                        state_next   = ST_ERD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

@@ rtl/dfs_maze_carver.sv @@
// For each direction the block skips a move that leaves the grid, reads the target and
// skips it when it is already open or cannot be pushed, writes and pushes a horizontal
// move, and for a vertical one also reads and writes the middle cell; a cell is popped
// by reading the stack and then loading the entry. Once the stack empties, each grid row
// is read from the grid memory, loaded and offered after the previous row was taken; the
// next item can be accepted in the cycle after the last row is taken.
// Reset is synchronous and active low; it returns the block to idle with an empty
// stack and a grid size of eleven. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "dfs_maze_carver_assert.svh"
module dfs_maze_carver (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // first_dir, second_dir, third_dir, fourth_dir
    input  wire logic [dmc_pkg::ORDER_W-1:0] s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // row_index, row_bits, zero padding
    output logic [dmc_pkg::OUT_W-1:0]        m_tdata,
    output logic                             m_tlast,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [dmc_pkg::COORD_W-1:0] cfg_data
);
    import dmc_pkg::*;

    logic [COORD_W-1:0] maze_size_reg;
    cmd_t               cmd;
    status_t            status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            maze_size_reg <= COORD_W'(SIZE_RESET);
        end else if (cfg_valid) begin
            maze_size_reg <= cfg_data;
        end
    end

    dmc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dmc_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .maze_size (maze_size_reg),
        .order     (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

    `DMC_ASSERT_NOW(a_no_input_while_emitting, m_tvalid, !s_tready, "input taken during emission")
    `DMC_ASSERT_NOW(a_row_in_range, m_tvalid, m_tdata[5:0] != 6'd63, "row index out of range")
    `DMC_ASSERT_NEXT(a_idle_after_last, m_tvalid && m_tready && m_tlast, !m_tvalid && s_tready,
                     "not idle after last row")
endmodule
`default_nettype wire
